FILE: hw/rtl/dtst_pkg.sv
// dtst_pkg: shared types and constants for the drag temperature sink pipeline
// used by drag_temperature_sink_term and its testbench; no dependencies
package dtst_pkg;

  // configuration register indexes
  localparam logic [2:0] REG_VON_KARMAN   = 3'd0;
  localparam logic [2:0] REG_LOG_HEIGHT   = 3'd1;
  localparam logic [2:0] REG_FLUX_SCALE   = 3'd2;
  localparam logic [2:0] REG_PROF_OFFSET  = 3'd3;
  localparam logic [2:0] REG_RELAX_RATE   = 3'd4;
  localparam logic [2:0] REG_SOIL_TEMP    = 3'd5;
  localparam logic [2:0] REG_DRAG_PER_HGT = 3'd6;
  localparam logic [2:0] REG_CD_LIMIT     = 3'd7;

  // register reset values
  localparam logic [16:0] VON_KARMAN_RST  = 17'd26214;
  localparam logic [30:0] RELAX_RATE_RST  = 31'd65536;
  localparam logic [30:0] SOIL_TEMP_RST   = 31'd19660800;
  localparam logic [30:0] CD_LIMIT_RST    = 31'd655360;

  // roughness floor of 1e-4 in Q8.24, ln 2 in Q0.32
  localparam logic [31:0] Z0_FLOOR = 32'd1678;
  localparam logic [32:0] LN2_Q32  = 33'd2977044472;

  // everything one cell carries down the pipeline
  typedef struct packed {
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic [30:0]        th;
    logic [30:0]        thu;
    logic [31:0]        z0;
    logic               blank;
    logic               drag;
    logic               sat;
    logic [63:0]        sx;
    logic [63:0]        sy;
    logic [63:0]        sz;
    logic [63:0]        rem_h;
    logic [63:0]        rem_a;
    logic [31:0]        root_h;
    logic [31:0]        root_a;
    logic [30:0]        lg_m;
    logic signed [23:0] lg_acc;
    logic signed [56:0] ln_prod;
    logic [32:0]        den_mag;
    logic [63:0]        drem1;
    logic [63:0]        drem2;
    logic [32:0]        dden2;
    logic [31:0]        q1;
    logic [31:0]        q2;
    logic               ovf1;
    logic               ovf2;
    logic signed [31:0] u2;
    logic [30:0]        cd;
    logic signed [31:0] a;
    logic signed [47:0] dterm;
    logic signed [31:0] ts;
    logic signed [31:0] delta;
    logic signed [31:0] diff;
    logic signed [31:0] relax;
    logic signed [31:0] sink;
  } stage_t;

endpackage

FILE: hw/rtl/drag_temperature_sink_term.sv
// drag_temperature_sink_term: pipelined terrain drag temperature sink, one cell per clock
// when not stalled; depends on dtst_pkg
//
// Accepts one grid cell per clock, unless a finished result is held by out_stall_i,
// and returns its sink at the end of the pipeline. The pipeline length is set by the two
// bit-per-stage chains: a 32-stage square root for the horizontal and full speeds
// and a 32-stage restoring divider pair for friction velocity and drag factor; the
// 16-step squaring log of roughness runs beside the root. All stages advance
// together and hold only while a result waits on out_stall_i. Configuration is to be
// written only while no cell is in flight; the block itself does not enforce this.
module drag_temperature_sink_term
  import dtst_pkg::*;
#(
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] vel_x_i,
  input  logic signed [31:0] vel_y_i,
  input  logic signed [31:0] vel_z_i,
  input  logic [30:0]        theta_cell_i,
  input  logic [30:0]        theta_above_i,
  input  logic [31:0]        roughness_i,
  input  logic               blank_flag_i,
  input  logic               drag_flag_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] sink_o,
  output logic               saturated_o
);

  localparam int W = (DATA_WIDTH < 24) ? 24 : ((DATA_WIDTH > 32) ? 32 : DATA_WIDTH);
  localparam logic signed [63:0] SMAX = (64'sd1 <<< (W - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  localparam int NS        = 75;
  localparam int ST_SQR    = 1;
  localparam int ST_SQINIT = 2;
  localparam int ST_LOGEND = 17;
  localparam int ST_ROOTB  = 3;
  localparam int ST_ROOTE  = 34;
  localparam int ST_LNMUL  = 18;
  localparam int ST_DEN    = 19;
  localparam int ST_DIVIN  = 35;
  localparam int ST_DIVB   = 36;
  localparam int ST_DIVE   = 67;
  localparam int ST_USTAR  = 68;
  localparam int ST_AMUL   = 69;
  localparam int ST_TS     = 70;
  localparam int ST_DELTA  = 71;
  localparam int ST_DIFF   = 72;
  localparam int ST_RELAX  = 73;
  localparam int ST_TOTAL  = 74;

  logic [16:0]        vk_q;
  logic signed [31:0] lhpm_q;
  logic signed [31:0] fs_q;
  logic signed [31:0] po_q;
  logic [30:0]        rr_q;
  logic [30:0]        soil_q;
  logic [30:0]        dph_q;
  logic [30:0]        cdlim_q;

  stage_t      pipe_q [NS];
  stage_t      pipe_d [NS];
  logic [NS-1:0] vld_q;
  logic        adv;

  function automatic logic signed [31:0] clampv(input logic signed [63:0] v);
    if (v > SMAX) return SMAX[31:0];
    if (v < SMIN) return SMIN[31:0];
    return v[31:0];
  endfunction

  function automatic logic overs(input logic signed [63:0] v);
    return (v > SMAX) || (v < SMIN);
  endfunction

  function automatic stage_t st_square(input stage_t s);
    logic signed [63:0] p;
    logic [4:0]         pos;
    logic signed [7:0]  e;
    logic [31:0]        sh;
    p = s.vx * s.vx;
    s.sx = p;
    p = s.vy * s.vy;
    s.sy = p;
    p = s.vz * s.vz;
    s.sz = p;
    pos = '0;
    for (int b = 0; b < 32; b++) begin
      if (s.z0[b]) pos = 5'(b);
    end
    sh = s.z0 << (5'd30 - pos);
    if (pos == 5'd31) s.lg_m = s.z0[31:1];
    else s.lg_m = sh[30:0];
    e = $signed({3'b000, pos}) - 8'sd24;
    s.lg_acc = {e, 16'h0000};
    return s;
  endfunction

  function automatic stage_t st_sqinit(input stage_t s);
    s.rem_h  = s.sx + s.sy;
    s.rem_a  = s.sx + s.sy + s.sz;
    s.root_h = '0;
    s.root_a = '0;
    return s;
  endfunction

  // one bit of the squaring log
  function automatic stage_t log_step(input stage_t s, input int i);
    logic [61:0] sq;
    logic [31:0] m2;
    sq = 62'(s.lg_m) * 62'(s.lg_m);
    m2 = sq[61:30];
    if (m2[31]) begin
      s.lg_m   = m2[31:1];
      s.lg_acc = s.lg_acc + signed'(24'd1 << i);
    end else begin
      s.lg_m = m2[30:0];
    end
    return s;
  endfunction

  // one root bit: rem holds x - root^2
  function automatic stage_t sqrt_step(input stage_t s, input int j);
    logic [65:0] th_h;
    logic [65:0] th_a;
    th_h = (66'(s.root_h) << (j + 1)) + (66'd1 << (2 * j));
    th_a = (66'(s.root_a) << (j + 1)) + (66'd1 << (2 * j));
    if (66'(s.rem_h) >= th_h) begin
      s.rem_h  = s.rem_h - th_h[63:0];
      s.root_h = s.root_h | (32'd1 << j);
    end
    if (66'(s.rem_a) >= th_a) begin
      s.rem_a  = s.rem_a - th_a[63:0];
      s.root_a = s.root_a | (32'd1 << j);
    end
    return s;
  endfunction

  function automatic stage_t st_lnmul(input stage_t s);
    s.ln_prod = 57'(s.lg_acc) * $signed(57'(LN2_Q32));
    return s;
  endfunction

  function automatic stage_t st_den(input stage_t s);
    logic signed [33:0] den;
    den = 34'(lhpm_q) - 34'($signed(s.ln_prod[56:32]));
    if (den < 0) s.den_mag = 33'(-den);
    else s.den_mag = 33'(den);
    return s;
  endfunction

  function automatic stage_t st_divinit(input stage_t s);
    logic [48:0] n1;
    n1 = 49'(s.root_h) * 49'(vk_q);
    s.drem1 = 64'(n1);
    s.drem2 = 64'(dph_q) << 16;
    s.dden2 = 33'(s.root_a) + 33'd1;
    // quotient would not fit in 32 bits
    s.ovf1  = (s.drem1 >> 32) >= 64'(s.den_mag);
    s.ovf2  = (s.drem2 >> 32) >= 64'(s.dden2);
    s.q1    = '0;
    s.q2    = '0;
    return s;
  endfunction

  function automatic stage_t div_step(input stage_t s, input int j);
    logic [65:0] t1;
    logic [65:0] t2;
    t1 = 66'(s.den_mag) << j;
    t2 = 66'(s.dden2) << j;
    if (66'(s.drem1) >= t1) begin
      s.drem1 = s.drem1 - t1[63:0];
      s.q1    = s.q1 | (32'd1 << j);
    end
    if (66'(s.drem2) >= t2) begin
      s.drem2 = s.drem2 - t2[63:0];
      s.q2    = s.q2 | (32'd1 << j);
    end
    return s;
  endfunction

  function automatic stage_t st_ustar(input stage_t s);
    logic [30:0]        us;
    logic [61:0]        uu;
    logic signed [63:0] v;
    if (s.den_mag == '0) begin
      us = '0;
    end else if (s.ovf1 || ($signed({32'd0, s.q1}) > SMAX)) begin
      us    = SMAX[30:0];
      s.sat = 1'b1;
    end else begin
      us = s.q1[30:0];
    end
    uu    = 62'(us) * 62'(us);
    v     = $signed(64'(uu >> 16));
    s.u2  = clampv(v);
    s.sat = s.sat | overs(v);
    if (s.ovf2 || (s.q2 > 32'(cdlim_q))) s.cd = cdlim_q;
    else s.cd = s.q2[30:0];
    return s;
  endfunction

  function automatic stage_t st_amul(input stage_t s);
    logic signed [63:0] pa;
    logic signed [31:0] ds;
    logic signed [63:0] pd;
    pa      = $signed({2'b00, s.th}) * s.u2;
    pa      = pa >>> 16;
    s.a     = clampv(pa);
    s.sat   = s.sat | overs(pa);
    ds      = $signed({1'b0, s.th}) - $signed({1'b0, soil_q});
    pd      = $signed({1'b0, s.cd}) * ds;
    pd      = pd >>> 16;
    s.dterm = pd[47:0];
    return s;
  endfunction

  function automatic stage_t st_ts(input stage_t s);
    logic signed [63:0] p;
    p     = s.a * fs_q;
    p     = p >>> 16;
    s.ts  = clampv(p);
    s.sat = s.sat | overs(p);
    return s;
  endfunction

  function automatic stage_t st_delta(input stage_t s);
    logic signed [63:0] p;
    p       = s.ts * po_q;
    p       = p >>> 16;
    s.delta = clampv(p);
    s.sat   = s.sat | overs(p);
    return s;
  endfunction

  function automatic stage_t st_diff(input stage_t s);
    logic signed [63:0] d;
    d      = $signed({33'd0, s.th}) - $signed({33'd0, s.thu}) - 64'(s.delta);
    s.diff = clampv(d);
    s.sat  = s.sat | overs(d);
    return s;
  endfunction

  function automatic stage_t st_relax(input stage_t s);
    logic signed [63:0] p;
    p       = s.diff * $signed({1'b0, rr_q});
    p       = p >>> 16;
    s.relax = clampv(p);
    s.sat   = s.sat | overs(p);
    return s;
  endfunction

  function automatic stage_t st_total(input stage_t s);
    logic signed [63:0] t;
    t = '0;
    if (s.blank) t = t + 64'(s.dterm);
    if (s.drag) t = t + 64'(s.relax);
    s.sink = clampv(t);
    s.sat  = s.sat | overs(t);
    return s;
  endfunction

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vk_q    <= VON_KARMAN_RST;
      lhpm_q  <= '0;
      fs_q    <= '0;
      po_q    <= '0;
      rr_q    <= RELAX_RATE_RST;
      soil_q  <= SOIL_TEMP_RST;
      dph_q   <= '0;
      cdlim_q <= CD_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_VON_KARMAN:   vk_q    <= cfg_data_i[16:0];
        REG_LOG_HEIGHT:   lhpm_q  <= cfg_data_i;
        REG_FLUX_SCALE:   fs_q    <= cfg_data_i;
        REG_PROF_OFFSET:  po_q    <= cfg_data_i;
        REG_RELAX_RATE:   rr_q    <= cfg_data_i[30:0];
        REG_SOIL_TEMP:    soil_q  <= cfg_data_i[30:0];
        REG_DRAG_PER_HGT: dph_q   <= cfg_data_i[30:0];
        REG_CD_LIMIT:     cdlim_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // whole pipeline moves unless the last word is held
  assign adv        = !(vld_q[NS-1] && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    pipe_d[0]       = '0;
    pipe_d[0].vx    = vel_x_i;
    pipe_d[0].vy    = vel_y_i;
    pipe_d[0].vz    = vel_z_i;
    pipe_d[0].th    = theta_cell_i;
    pipe_d[0].thu   = theta_above_i;
    pipe_d[0].z0    = (roughness_i < Z0_FLOOR) ? Z0_FLOOR : roughness_i;
    pipe_d[0].blank = blank_flag_i;
    pipe_d[0].drag  = drag_flag_i;
  end

  for (genvar k = 1; k < NS; k++) begin : g_stage
    always_comb begin
      pipe_d[k] = pipe_q[k-1];
      if (k == ST_SQR) pipe_d[k] = st_square(pipe_d[k]);
      if (k == ST_SQINIT) pipe_d[k] = st_sqinit(pipe_d[k]);
      if (k >= ST_SQINIT && k <= ST_LOGEND) pipe_d[k] = log_step(pipe_d[k], ST_LOGEND - k);
      if (k >= ST_ROOTB && k <= ST_ROOTE) pipe_d[k] = sqrt_step(pipe_d[k], ST_ROOTE - k);
      if (k == ST_LNMUL) pipe_d[k] = st_lnmul(pipe_d[k]);
      if (k == ST_DEN) pipe_d[k] = st_den(pipe_d[k]);
      if (k == ST_DIVIN) pipe_d[k] = st_divinit(pipe_d[k]);
      if (k >= ST_DIVB && k <= ST_DIVE) pipe_d[k] = div_step(pipe_d[k], ST_DIVE - k);
      if (k == ST_USTAR) pipe_d[k] = st_ustar(pipe_d[k]);
      if (k == ST_AMUL) pipe_d[k] = st_amul(pipe_d[k]);
      if (k == ST_TS) pipe_d[k] = st_ts(pipe_d[k]);
      if (k == ST_DELTA) pipe_d[k] = st_delta(pipe_d[k]);
      if (k == ST_DIFF) pipe_d[k] = st_diff(pipe_d[k]);
      if (k == ST_RELAX) pipe_d[k] = st_relax(pipe_d[k]);
      if (k == ST_TOTAL) pipe_d[k] = st_total(pipe_d[k]);
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_reg
    always_ff @(posedge clk_i) begin
      if (adv) pipe_q[k] <= pipe_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NS-2:0], in_valid_i};
    end
  end

  assign out_valid_o = vld_q[NS-1];
  assign sink_o      = pipe_q[NS-1].sink;
  assign saturated_o = pipe_q[NS-1].sat;

endmodule

FILE: hw/rtl/dtst_check.sv
// dtst_check: port-level checks for drag_temperature_sink_term, bound to the top level
// no package dependencies
module dtst_check (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [31:0] sink_o,
  input logic               saturated_o
);

  // held result word stays up
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(sink_o) && $stable(saturated_o))
    else $error("output word changed while stalled");

  // input only backs up when a finished word is held
  a_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without a held output");

  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

endmodule

bind drag_temperature_sink_term dtst_check u_dtst_check (.*);

FILE: tb/tb_drag_temperature_sink_term.sv
// tb_drag_temperature_sink_term: self-checking bench for the drag temperature sink pipeline
// depends on dtst_pkg and drag_temperature_sink_term; a local model predicts unknown sinks
module tb_drag_temperature_sink_term;
  import dtst_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] vx, vy, vz;
    logic [30:0]        th, thu;
    logic [31:0]        z0;
    bit                 blank, drag;
    bit                 known;
    logic signed [31:0] sink;
    bit                 sat;
  } cell_row_t;

  typedef struct {
    logic signed [31:0] sink;
    bit                 sat;
  } sink_word_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [2:0] cfg_idx;
  logic [31:0] cfg_data;
  logic in_valid, in_stall, out_valid, out_stall;
  logic signed [31:0] vel_x, vel_y, vel_z, sink;
  logic [30:0] theta_cell, theta_above;
  logic [31:0] roughness;
  logic blank_flag, drag_flag, saturated;

  // shadow of the configuration registers
  longint unsigned vk, relax_rt, soil_t, drag_ph, cd_lim;
  longint log_hgt, flux_sc, prof_off;

  sink_word_t sink_expect_q[$];
  int errors = 0;
  int send_gap_max, recv_gap_max;
  bit long_hold;

  drag_temperature_sink_term u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vel_x_i(vel_x), .vel_y_i(vel_y), .vel_z_i(vel_z),
    .theta_cell_i(theta_cell), .theta_above_i(theta_above), .roughness_i(roughness),
    .blank_flag_i(blank_flag), .drag_flag_i(drag_flag),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .sink_o(sink), .saturated_o(saturated)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp32(longint v, inout bit sat);
    if (v > 64'sd2147483647) begin
      sat = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // natural log of a Q8.24 roughness, Q16.16 result, by repeated squaring
  function automatic longint ln_rough(longint unsigned z);
    int p;
    longint unsigned m;
    longint lg;
    p = 31;
    while (p > 0 && z[p] == 1'b0) p--;
    if (p <= 30) m = z << (30 - p);
    else m = z >> 1;
    lg = longint'(p - 24) * 65536;
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m >>= 1;
        lg += 64'sd1 << i;
      end
    end
    return (lg * longint'(LN2_Q32)) >>> 32;
  endfunction

  function automatic sink_word_t predict_sink(cell_row_t c);
    longint vx, vy, vz, th, thu, den, ustar, u2, a, ts, delta, diff, relax, dterm, total;
    longint unsigned z0, h2, wspd, spd, den_mag, q, cd;
    bit sat;
    sink_word_t r;
    sat = 1'b0;
    vx = c.vx;
    vy = c.vy;
    vz = c.vz;
    th = c.th;
    thu = c.thu;
    z0 = c.z0;
    if (z0 < Z0_FLOOR) z0 = Z0_FLOOR;
    h2 = vx * vx + vy * vy;
    wspd = floor_root(h2);
    spd = floor_root(h2 + longint'(vz * vz));
    den = log_hgt - ln_rough(z0);
    den_mag = (den < 0) ? -den : den;
    if (den_mag == 0) begin
      ustar = 0;
    end else begin
      q = (wspd * vk) / den_mag;
      if (q > 64'd2147483647) begin
        sat = 1'b1;
        q = 64'd2147483647;
      end
      ustar = q;
    end
    u2 = clamp32((ustar * ustar) >>> 16, sat);
    a = clamp32((th * u2) >>> 16, sat);
    ts = clamp32((a * flux_sc) >>> 16, sat);
    delta = clamp32((ts * prof_off) >>> 16, sat);
    diff = clamp32(th - thu - delta, sat);
    relax = clamp32((diff * longint'(relax_rt)) >>> 16, sat);
    cd = (drag_ph << 16) / (spd + 1);
    if (cd > cd_lim) cd = cd_lim;
    dterm = (longint'(cd) * (th - longint'(soil_t))) >>> 16;
    total = 0;
    if (c.blank) total += dterm;
    if (c.drag) total += relax;
    total = clamp32(total, sat);
    r.sink = total[31:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic flag_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= 30) $display("%0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_data = data;
    case (idx)
      REG_VON_KARMAN:   vk = data[16:0];
      REG_LOG_HEIGHT:   log_hgt = $signed(data);
      REG_FLUX_SCALE:   flux_sc = $signed(data);
      REG_PROF_OFFSET:  prof_off = $signed(data);
      REG_RELAX_RATE:   relax_rt = data[30:0];
      REG_SOIL_TEMP:    soil_t = data[30:0];
      REG_DRAG_PER_HGT: drag_ph = data[30:0];
      default:          cd_lim = data[30:0];
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic drain();
    while (sink_expect_q.size() != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic send_cell(cell_row_t c);
    int gap;
    sink_word_t w;
    gap = $urandom_range(0, send_gap_max);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    vel_x = c.vx;
    vel_y = c.vy;
    vel_z = c.vz;
    theta_cell = c.th;
    theta_above = c.thu;
    roughness = c.z0;
    blank_flag = c.blank;
    drag_flag = c.drag;
    in_valid = 1'b1;
    if (c.known) begin
      w.sink = c.sink;
      w.sat = c.sat;
    end else begin
      w = predict_sink(c);
    end
    do @(posedge clk); while (in_stall);
    sink_expect_q.push_back(w);
    @(negedge clk);
  endtask

  // wide spread of magnitudes, signed
  function automatic logic [31:0] spread();
    return $signed($urandom()) >>> $urandom_range(0, 31);
  endfunction

  function automatic cell_row_t random_cell();
    cell_row_t c;
    bit wide;
    wide = ($urandom_range(0, 7) == 0);
    c.vx = wide ? $urandom() : $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    c.vy = wide ? $urandom() : $signed($urandom_range(0, 40 << 16)) - (20 << 16);
    c.vz = wide ? $urandom() : $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    c.th = wide ? $urandom() : $urandom_range(250 << 16, 330 << 16);
    c.thu = wide ? $urandom() : $urandom_range(250 << 16, 330 << 16);
    c.z0 = $urandom() >> $urandom_range(0, 31);
    c.blank = $urandom_range(0, 1);
    c.drag = $urandom_range(0, 1);
    c.known = 1'b0;
    return c;
  endfunction

  cell_row_t directed_rows[] = '{
    '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0},
    '{0, 0, 0, 31'h7FFFFFFF, 0, 32'h01000000, 0, 1, 1, 32'sh7FFFFFFF, 0},
    '{0, 0, 0, 0, 31'h7FFFFFFF, 32'h01000000, 0, 1, 1, 32'sh80000001, 0},
    '{0, 0, 0, 31'h7FFFFFFF, 0, 32'h01000000, 1, 0, 1, 0, 0},
    // zero log denominator: ln(1.0) equals the reset height term
    '{32'sh7FFFFFFF, 32'sh80000000, 0, 5 << 16, 2 << 16, 32'h01000000, 0, 1, 1, 3 << 16, 0},
    '{32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 31'h7FFFFFFF, 0, 0, 1, 1, 0, 0, 0},
    '{32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 31'h7FFFFFFF, 32'hFFFFFFFF, 1, 1, 0, 0, 0},
    '{3 << 16, -4 << 16, 1 << 16, 300 << 16, 301 << 16, 1677, 1, 1, 0, 0, 0},
    '{3 << 16, -4 << 16, 1 << 16, 300 << 16, 301 << 16, 1678, 0, 1, 0, 0, 0},
    '{-1, 1, -1, 31'h7FFFFFFF, 31'h7FFFFFFF, 1679, 1, 0, 0, 0, 0},
    '{32'sh55555555, 32'shAAAAAAAA, 32'sh0F0F0F0F, 31'h2AAAAAAA, 31'h55555555,
      32'h5A5A5A5A, 1, 1, 0, 0, 0}
  };

  // result side: random stall per word, plus one long hold-off on request
  initial begin
    int g;
    sink_word_t w;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall = 1'b1;
        for (int k = 0; k < 400; k++) @(negedge clk);
        long_hold = 1'b0;
      end
      g = $urandom_range(0, recv_gap_max);
      if (g != 0) begin
        out_stall = 1'b1;
        repeat (g) @(negedge clk);
      end
      out_stall = 1'b0;
      do @(posedge clk); while (!out_valid);
      if (sink_expect_q.size() == 0) begin
        flag_mismatch("unexpected word, sink", sink, 0);
      end else begin
        w = sink_expect_q.pop_front();
        if (sink !== w.sink) flag_mismatch("sink", sink, w.sink);
        if (saturated !== w.sat) flag_mismatch("saturated", saturated, w.sat);
      end
    end
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    cell_row_t c;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = REG_VON_KARMAN;
    cfg_data = '0;
    in_valid = 1'b0;
    vel_x = '0;
    vel_y = '0;
    vel_z = '0;
    theta_cell = '0;
    theta_above = '0;
    roughness = '0;
    blank_flag = 1'b0;
    drag_flag = 1'b0;
    long_hold = 1'b0;
    send_gap_max = 14;
    recv_gap_max = 14;
    vk = VON_KARMAN_RST;
    log_hgt = 0;
    flux_sc = 0;
    prof_off = 0;
    relax_rt = RELAX_RATE_RST;
    soil_t = SOIL_TEMP_RST;
    drag_ph = 0;
    cd_lim = CD_LIMIT_RST;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i]) send_cell(directed_rows[i]);

    for (int ph = 0; ph < 8; ph++) begin
      in_valid = 1'b0;
      drain();
      case (ph)
        0: begin
          write_reg(REG_VON_KARMAN, 0);
          write_reg(REG_LOG_HEIGHT, 0);
          write_reg(REG_FLUX_SCALE, 0);
          write_reg(REG_PROF_OFFSET, 0);
          write_reg(REG_RELAX_RATE, 0);
          write_reg(REG_SOIL_TEMP, 0);
          write_reg(REG_DRAG_PER_HGT, 0);
          write_reg(REG_CD_LIMIT, 0);
        end
        1: begin
          write_reg(REG_VON_KARMAN, 65536);
          write_reg(REG_LOG_HEIGHT, 32'h7FFFFFFF);
          write_reg(REG_FLUX_SCALE, 32'h7FFFFFFF);
          write_reg(REG_PROF_OFFSET, 32'h7FFFFFFF);
          write_reg(REG_RELAX_RATE, 32'h7FFFFFFF);
          write_reg(REG_SOIL_TEMP, 32'h7FFFFFFF);
          write_reg(REG_DRAG_PER_HGT, 32'h7FFFFFFF);
          write_reg(REG_CD_LIMIT, 32'h7FFFFFFF);
        end
        2: begin
          write_reg(REG_LOG_HEIGHT, 32'h80000000);
          write_reg(REG_FLUX_SCALE, 32'h80000000);
          write_reg(REG_PROF_OFFSET, 32'h80000000);
          write_reg(REG_CD_LIMIT, 20 << 16);
        end
        default: begin
          write_reg(REG_VON_KARMAN, $urandom_range(0, 65536));
          write_reg(REG_LOG_HEIGHT, $signed($urandom_range(0, 24 << 16)) - (6 << 16));
          write_reg(REG_FLUX_SCALE, spread());
          write_reg(REG_PROF_OFFSET, spread());
          write_reg(REG_RELAX_RATE, $urandom() >> $urandom_range(1, 31));
          write_reg(REG_SOIL_TEMP, $urandom_range(250 << 16, 320 << 16));
          write_reg(REG_DRAG_PER_HGT, $urandom() >> $urandom_range(1, 31));
          write_reg(REG_CD_LIMIT, $urandom() >> $urandom_range(1, 31));
        end
      endcase
      send_gap_max = (ph == 4) ? 0 : 14;
      recv_gap_max = (ph == 4 || ph == 5) ? 0 : 14;
      if (ph == 3) long_hold = 1'b1;
      for (int n = 0; n < 150; n++) begin
        c = random_cell();
        send_cell(c);
      end
    end

    in_valid = 1'b0;
    drain();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
